### rtl/core/mep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg
// Shared constants, types and Q8.56 saturating helpers of the escape-time
// pixel pipeline.
// ----------------------------------------------------------------------------
package mep_pkg;

    localparam int MAX_STEPS  = 127;
    localparam int COORD_BITS = 12;
    localparam int PAL_DEPTH  = 127;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int PAL_IDX_W  = $clog2(PAL_DEPTH);
    localparam int FRAME_W    = 13;
    localparam int ADDR_W     = 24;
    localparam int RGB_W      = 24;
    localparam int ESC_W      = 7;
    localparam int Q_W        = 64;
    localparam int SCALE_W    = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int OFF_W      = FRAME_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_REAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_IMAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    localparam logic [Q_W-1:0] Q_FOUR  = 64'h0400_0000_0000_0000;
    localparam logic [Q_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [Q_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;
    localparam logic [RGB_W-1:0] RGB_WHITE = 24'hFFFFFF;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 63'd205878840108365;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 13'd700;

    typedef struct packed {
        logic [Q_W-1:0]     center_real;
        logic [Q_W-1:0]     center_imag;
        logic [SCALE_W-1:0] scale_real;
        logic [SCALE_W-1:0] scale_imag;
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic [Q_W-1:0]    x;
        logic [Q_W-1:0]    y;
        logic [Q_W-1:0]    cr;
        logic [Q_W-1:0]    ci;
        logic              escaped;
        logic [STEP_W-1:0] step;
        logic [ADDR_W-1:0] addr;
    } t_item;

    localparam logic [RGB_W-1:0] PALETTE [PAL_DEPTH] = '{
        {8'd0,8'd0,8'd100},     {8'd22,8'd0,8'd99},     {8'd31,8'd1,8'd98},
        {8'd38,8'd3,8'd95},     {8'd44,8'd4,8'd92},     {8'd49,8'd6,8'd88},
        {8'd53,8'd8,8'd84},     {8'd58,8'd10,8'd79},    {8'd62,8'd12,8'd74},
        {8'd66,8'd14,8'd69},    {8'd69,8'd17,8'd64},    {8'd72,8'd19,8'd60},
        {8'd76,8'd22,8'd56},    {8'd79,8'd24,8'd53},    {8'd82,8'd27,8'd51},
        {8'd85,8'd30,8'd50},    {8'd88,8'd32,8'd50},    {8'd90,8'd35,8'd50},
        {8'd93,8'd38,8'd52},    {8'd95,8'd41,8'd55},    {8'd98,8'd43,8'd58},
        {8'd100,8'd46,8'd62},   {8'd103,8'd49,8'd67},   {8'd105,8'd52,8'd72},
        {8'd107,8'd55,8'd77},   {8'd110,8'd58,8'd82},   {8'd112,8'd61,8'd86},
        {8'd114,8'd64,8'd90},   {8'd116,8'd68,8'd94},   {8'd118,8'd71,8'd97},
        {8'd120,8'd74,8'd99},   {8'd122,8'd77,8'd99},   {8'd124,8'd80,8'd99},
        {8'd126,8'd83,8'd98},   {8'd128,8'd87,8'd96},   {8'd130,8'd90,8'd93},
        {8'd132,8'd93,8'd90},   {8'd133,8'd97,8'd85},   {8'd135,8'd100,8'd81},
        {8'd137,8'd103,8'd76},  {8'd139,8'd107,8'd71},  {8'd140,8'd110,8'd66},
        {8'd142,8'd113,8'd62},  {8'd144,8'd117,8'd58},  {8'd145,8'd120,8'd54},
        {8'd147,8'd124,8'd52},  {8'd149,8'd127,8'd50},  {8'd150,8'd131,8'd50},
        {8'd152,8'd134,8'd50},  {8'd154,8'd138,8'd51},  {8'd155,8'd141,8'd54},
        {8'd157,8'd145,8'd57},  {8'd158,8'd148,8'd60},  {8'd160,8'd152,8'd65},
        {8'd161,8'd156,8'd70},  {8'd163,8'd159,8'd75},  {8'd164,8'd163,8'd80},
        {8'd166,8'd166,8'd84},  {8'd167,8'd170,8'd89},  {8'd168,8'd174,8'd93},
        {8'd170,8'd177,8'd96},  {8'd171,8'd181,8'd98},  {8'd173,8'd185,8'd99},
        {8'd174,8'd189,8'd99},  {8'd176,8'd192,8'd99},  {8'd177,8'd196,8'd97},
        {8'd178,8'd200,8'd95},  {8'd180,8'd203,8'd91},  {8'd181,8'd207,8'd87},
        {8'd182,8'd211,8'd83},  {8'd184,8'd215,8'd78},  {8'd185,8'd219,8'd73},
        {8'd186,8'd222,8'd68},  {8'd187,8'd226,8'd63},  {8'd189,8'd230,8'd59},
        {8'd190,8'd234,8'd56},  {8'd191,8'd238,8'd53},  {8'd193,8'd241,8'd51},
        {8'd194,8'd245,8'd50},  {8'd195,8'd249,8'd50},  {8'd196,8'd253,8'd51},
        {8'd198,8'd255,8'd52},  {8'd199,8'd255,8'd55},  {8'd200,8'd255,8'd59},
        {8'd201,8'd255,8'd63},  {8'd202,8'd255,8'd68},  {8'd204,8'd255,8'd73},
        {8'd205,8'd255,8'd78},  {8'd206,8'd255,8'd82},  {8'd207,8'd255,8'd87},
        {8'd208,8'd255,8'd91},  {8'd209,8'd255,8'd94},  {8'd211,8'd255,8'd97},
        {8'd212,8'd255,8'd99},  {8'd213,8'd255,8'd99},  {8'd214,8'd255,8'd99},
        {8'd215,8'd255,8'd98},  {8'd216,8'd255,8'd96},  {8'd217,8'd255,8'd93},
        {8'd218,8'd255,8'd89},  {8'd220,8'd255,8'd85},  {8'd221,8'd255,8'd80},
        {8'd222,8'd255,8'd75},  {8'd223,8'd255,8'd70},  {8'd224,8'd255,8'd65},
        {8'd225,8'd255,8'd61},  {8'd226,8'd255,8'd57},  {8'd227,8'd255,8'd54},
        {8'd228,8'd255,8'd51},  {8'd229,8'd255,8'd50},  {8'd230,8'd255,8'd50},
        {8'd231,8'd255,8'd50},  {8'd232,8'd255,8'd52},  {8'd233,8'd255,8'd54},
        {8'd234,8'd255,8'd57},  {8'd235,8'd255,8'd61},  {8'd236,8'd255,8'd66},
        {8'd237,8'd255,8'd70},  {8'd238,8'd255,8'd75},  {8'd239,8'd255,8'd80},
        {8'd240,8'd255,8'd85},  {8'd242,8'd255,8'd89},  {8'd242,8'd255,8'd93},
        {8'd243,8'd255,8'd96},  {8'd244,8'd255,8'd98},  {8'd245,8'd255,8'd99},
        {8'd246,8'd255,8'd99}
    };

    // two's complement add, clamped to the signed 64 bit range
    function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [Q_W-1:0] s;
        s = a + b;
        if (a[Q_W-1] == b[Q_W-1] && s[Q_W-1] != a[Q_W-1])
            return a[Q_W-1] ? SAT_MIN : SAT_MAX;
        return s;
    endfunction

    // magnitude product -> signed floor(p / 2^sh), clamped to 64 bits
    function automatic logic [Q_W-1:0] sat_mag(input logic [2*Q_W-1:0] p,
                                               input int unsigned       sh,
                                               input logic              neg);
        logic [2*Q_W-1:0] q;
        logic             rem;
        q   = p >> sh;
        rem = |(p & ((128'd1 << sh) - 128'd1));
        if (neg && rem)
            q = q + 128'd1;
        if (!neg)
            return (|q[2*Q_W-1:Q_W-1]) ? SAT_MAX : q[Q_W-1:0];
        return (|q[2*Q_W-1:Q_W] || q[Q_W-1:0] > SAT_MIN) ? SAT_MIN
                                                          : (64'd0 - q[Q_W-1:0]);
    endfunction

endpackage

### rtl/core/mep_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_map
// Frame check, framebuffer address and pixel to c mapping, four stages.
// ----------------------------------------------------------------------------
module mep_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [mep_pkg::COORD_BITS-1:0]  i_col,
    input  logic [mep_pkg::COORD_BITS-1:0]  i_row,
    input  mep_pkg::t_cfg                   i_cfg,
    output logic                            o_valid,
    output mep_pkg::t_item                  o_item
);
    import mep_pkg::*;

    localparam int MAG_W = FRAME_W;
    localparam int LO_W  = MAG_W + 32;
    localparam int HI_W  = MAG_W + SCALE_W - 32;

    logic [OFF_W-1:0] off_r, off_i;
    logic [MAG_W-1:0] mag_r, mag_i;
    logic             in_frame;
    logic [COORD_BITS+FRAME_W-1:0] addr_full;

    logic             r1_valid;
    logic [MAG_W-1:0] r1_mag_r, r1_mag_i;
    logic             r1_neg_r, r1_neg_i;
    logic [ADDR_W-1:0] r1_addr;

    logic             r2_valid;
    logic [LO_W-1:0]  r2_lo_r, r2_lo_i;
    logic [HI_W-1:0]  r2_hi_r, r2_hi_i;
    logic             r2_neg_r, r2_neg_i;
    logic [ADDR_W-1:0] r2_addr;

    logic             r3_valid;
    logic [Q_W-1:0]   r3_off_r, r3_off_i;
    logic [ADDR_W-1:0] r3_addr;

    logic             r4_valid;
    t_item            r4_item;

    always_comb begin
        in_frame = ({1'b0, i_col} < i_cfg.frame_width) &&
                   ({1'b0, i_row} < i_cfg.frame_height);
        off_r = {1'b0, i_col, 1'b0} - {1'b0, i_cfg.frame_width};
        off_i = {1'b0, i_row, 1'b0} - {1'b0, i_cfg.frame_height};
        mag_r = off_r[OFF_W-1] ? MAG_W'(-off_r) : off_r[MAG_W-1:0];
        mag_i = off_i[OFF_W-1] ? MAG_W'(-off_i) : off_i[MAG_W-1:0];
        addr_full = (COORD_BITS+FRAME_W)'(i_row * i_cfg.frame_width)
                  + (COORD_BITS+FRAME_W)'(i_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid && in_frame;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag_r <= mag_r;
            r1_mag_i <= mag_i;
            r1_neg_r <= off_r[OFF_W-1];
            r1_neg_i <= off_i[OFF_W-1];
            r1_addr  <= addr_full[ADDR_W-1:0];

            r2_lo_r  <= r1_mag_r * i_cfg.scale_real[31:0];
            r2_hi_r  <= r1_mag_r * i_cfg.scale_real[SCALE_W-1:32];
            r2_lo_i  <= r1_mag_i * i_cfg.scale_imag[31:0];
            r2_hi_i  <= r1_mag_i * i_cfg.scale_imag[SCALE_W-1:32];
            r2_neg_r <= r1_neg_r;
            r2_neg_i <= r1_neg_i;
            r2_addr  <= r1_addr;

            r3_off_r <= sat_mag((2*Q_W)'(r2_lo_r) + ((2*Q_W)'(r2_hi_r) << 32), 0, r2_neg_r);
            r3_off_i <= sat_mag((2*Q_W)'(r2_lo_i) + ((2*Q_W)'(r2_hi_i) << 32), 0, r2_neg_i);
            r3_addr  <= r2_addr;

            r4_item.x       <= '0;
            r4_item.y       <= '0;
            r4_item.cr      <= sat_add(i_cfg.center_real, r3_off_r);
            r4_item.ci      <= sat_add(i_cfg.center_imag, r3_off_i);
            r4_item.escaped <= 1'b0;
            r4_item.step    <= '0;
            r4_item.addr    <= r3_addr;
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;

endmodule

### rtl/core/mep_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_cell
// One escape-time step: |z|^2 test, then z = z^2 + c, five stages.
// ----------------------------------------------------------------------------
module mep_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [mep_pkg::STEP_W-1:0]  i_step_idx,
    input  logic                        i_valid,
    input  mep_pkg::t_item              i_item,
    output logic                        o_valid,
    output mep_pkg::t_item              o_item
);
    import mep_pkg::*;

    localparam int H = Q_W / 2;

    logic [4:1]       r_valid;
    t_item            r1_item, r2_item, r3_item, r4_item, r5_item;

    logic [Q_W-1:0]   r1_mx, r1_my;
    logic             r1_neg;

    logic [Q_W-1:0]   r2_xx_ll, r2_xx_lh, r2_xx_hh;
    logic [Q_W-1:0]   r2_yy_ll, r2_yy_lh, r2_yy_hh;
    logic [Q_W-1:0]   r2_xy_ll, r2_xy_lh, r2_xy_hl, r2_xy_hh;
    logic             r2_neg;

    logic [2*Q_W-1:0] r3_pxx, r3_pyy, r3_pxy;
    logic             r3_neg;

    logic [Q_W-1:0]   r4_xx, r4_yy, r4_xy2, r4_sq;
    logic [Q_W-1:0]   xx_sat, yy_sat;

    logic             r5_valid;
    logic             hit;

    assign xx_sat = sat_mag(r3_pxx, 56, 1'b0);
    assign yy_sat = sat_mag(r3_pyy, 56, 1'b0);
    assign hit    = !r4_item.escaped && (r4_sq > Q_FOUR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= {r_valid[3:1], i_valid};
            r5_valid <= r_valid[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitudes, sign of the cross term
            r1_mx   <= i_item.x[Q_W-1] ? (64'd0 - i_item.x) : i_item.x;
            r1_my   <= i_item.y[Q_W-1] ? (64'd0 - i_item.y) : i_item.y;
            r1_neg  <= i_item.x[Q_W-1] ^ i_item.y[Q_W-1];
            r1_item <= i_item;

            // 32 x 32 partial products
            r2_xx_ll <= r1_mx[H-1:0] * r1_mx[H-1:0];
            r2_xx_lh <= r1_mx[H-1:0] * r1_mx[Q_W-1:H];
            r2_xx_hh <= r1_mx[Q_W-1:H] * r1_mx[Q_W-1:H];
            r2_yy_ll <= r1_my[H-1:0] * r1_my[H-1:0];
            r2_yy_lh <= r1_my[H-1:0] * r1_my[Q_W-1:H];
            r2_yy_hh <= r1_my[Q_W-1:H] * r1_my[Q_W-1:H];
            r2_xy_ll <= r1_mx[H-1:0] * r1_my[H-1:0];
            r2_xy_lh <= r1_mx[H-1:0] * r1_my[Q_W-1:H];
            r2_xy_hl <= r1_mx[Q_W-1:H] * r1_my[H-1:0];
            r2_xy_hh <= r1_mx[Q_W-1:H] * r1_my[Q_W-1:H];
            r2_neg   <= r1_neg;
            r2_item  <= r1_item;

            // the square's cross partial counts twice
            r3_pxx <= {r2_xx_hh, r2_xx_ll} + ((2*Q_W)'(r2_xx_lh) << (H + 1));
            r3_pyy <= {r2_yy_hh, r2_yy_ll} + ((2*Q_W)'(r2_yy_lh) << (H + 1));
            r3_pxy <= {r2_xy_hh, r2_xy_ll} + ((2*Q_W)'(r2_xy_lh) << H)
                                           + ((2*Q_W)'(r2_xy_hl) << H);
            r3_neg  <= r2_neg;
            r3_item <= r2_item;

            r4_xx   <= xx_sat;
            r4_yy   <= yy_sat;
            r4_xy2  <= sat_mag(r3_pxy, 55, r3_neg);
            r4_sq   <= sat_add(xx_sat, yy_sat);
            r4_item <= r3_item;

            r5_item <= r4_item;
            if (hit) begin
                r5_item.escaped <= 1'b1;
                r5_item.step    <= i_step_idx;
            end else if (!r4_item.escaped) begin
                // difference of squares wraps, only the sums clamp
                r5_item.x <= sat_add(r4_xx - r4_yy, r4_item.cr);
                r5_item.y <= sat_add(r4_xy2, r4_item.ci);
            end
        end
    end

    assign o_valid = r5_valid;
    assign o_item  = r5_item;

endmodule

### rtl/core/mandelbrot_escape_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time coloring of one pixel per request, fully unrolled pipeline.
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       slave      i_in_valid / o_in_ready    i_pixel_col, i_pixel_row
// out      master     o_out_valid / i_out_ready  o_pixel_addr, o_escape_step,
//                                                o_inside_set, o_rgb_word
// cfg      slave      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one request enters per cycle while the pipe advances; each request passes
// the mapping stages, one five-stage cell per step and the output register.
// a request outside the frame is taken and produces nothing.
// the whole pipe advances together whenever the output register is free,
// so a stall holds every stage in place.
// reset is synchronous, clears valid bits and loads the configuration defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mep_pkg::COORD_BITS-1:0]    i_pixel_col,
    input  logic [mep_pkg::COORD_BITS-1:0]    i_pixel_row,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mep_pkg::ADDR_W-1:0]        o_pixel_addr,
    output logic [mep_pkg::ESC_W-1:0]         o_escape_step,
    output logic                              o_inside_set,
    output logic [mep_pkg::RGB_W-1:0]         o_rgb_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::Q_W-1:0]           i_cfg_data
);
    import mep_pkg::*;

    t_cfg              r_cfg;
    logic              adv;
    logic              v [MAX_STEPS+1];
    t_item             it [MAX_STEPS+1];

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [ESC_W-1:0]  r_step;
    logic              r_inside;
    logic [RGB_W-1:0]  r_rgb;
    logic [PAL_IDX_W-1:0] pal_idx;
    t_item             last;

    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_real  <= '0;
            r_cfg.center_imag  <= '0;
            r_cfg.scale_real   <= SCALE_RESET;
            r_cfg.scale_imag   <= SCALE_RESET;
            r_cfg.frame_width  <= FRAME_RESET;
            r_cfg.frame_height <= FRAME_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_REAL:  r_cfg.center_real  <= i_cfg_data;
                REG_CENTER_IMAG:  r_cfg.center_imag  <= i_cfg_data;
                REG_SCALE_REAL:   r_cfg.scale_real   <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_IMAG:   r_cfg.scale_imag   <= i_cfg_data[SCALE_W-1:0];
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    mep_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_col   (i_pixel_col),
        .i_row   (i_pixel_row),
        .i_cfg   (r_cfg),
        .o_valid (v[0]),
        .o_item  (it[0])
    );

    for (genvar k = 0; k < MAX_STEPS; k++) begin : g_cell
        mep_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (adv),
            .i_step_idx (STEP_W'(k)),
            .i_valid    (v[k]),
            .i_item     (it[k]),
            .o_valid    (v[k+1]),
            .o_item     (it[k+1])
        );
    end

    assign last = it[MAX_STEPS];

    always_comb begin
        if (int'(last.step) < PAL_DEPTH)
            pal_idx = PAL_IDX_W'(last.step);
        else
            pal_idx = PAL_IDX_W'(PAL_DEPTH - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (adv)
            r_out_valid <= v[MAX_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_addr   <= last.addr;
            r_inside <= !last.escaped;
            r_step   <= last.escaped ? ESC_W'(last.step) : ESC_W'(MAX_STEPS);
            r_rgb    <= last.escaped ? PALETTE[pal_idx] : RGB_WHITE;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_addr  = r_addr;
    assign o_escape_step = r_step;
    assign o_inside_set  = r_inside;
    assign o_rgb_word    = r_rgb;

    a_inside_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_set |-> o_rgb_word == RGB_WHITE)
        else $error("inside pixel not white");

    a_inside_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_set |-> o_escape_step == ESC_W'(MAX_STEPS))
        else $error("inside pixel with wrong step");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(v[0]) && $stable(it[0].addr))
        else $error("mapping stage moved during stall");

endmodule
